[hw/rtl/bia_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap id allocator package
// Sizes, request and response types, status codes and the bit search helper.
// ----------------------------------------------------------------------------
package bia_pkg;

  localparam int ID_COUNT  = 1024;
  localparam int WORD_BITS = 32;
  localparam int WORDS     = (ID_COUNT - 1) / WORD_BITS + 1;
  localparam int ID_LIMIT  = WORDS * WORD_BITS;
  localparam int ID_W      = 10;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int ADDR_W    = $clog2(WORDS);
  localparam int CNT_W     = $clog2(WORDS + 1);

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_W-1:0]    waddr_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_FULL     = 2'd1,
    STS_BAD_ID   = 2'd2,
    STS_NOT_USED = 2'd3
  } status_t;

  typedef struct packed {
    logic            command;
    logic [ID_W-1:0] free_id;
  } bia_in_t;

  typedef struct packed {
    logic [ID_W-1:0] given_id;
    logic [1:0]      status;
  } bia_out_t;

  // Access bundle from the control logic to the bitmap memory.
  typedef struct packed {
    logic   re;
    waddr_t raddr;
    logic   we;
    waddr_t waddr;
    word_t  wdata;
  } bia_mem_req_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [BIT_W-1:0] lowest_set(input word_t x);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (x[b]) begin
        idx = BIT_W'(b);
      end
    end
    return idx;
  endfunction

endpackage

[hw/rtl/bitmap_id_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap id allocator
// Next-fit allocator of unique ids over a used-bitmap held in memory.
// ----------------------------------------------------------------------------
// Usage:
// A request on the in_ channel either allocates a new id (command 0) or
// frees in_data.free_id (command 1). Every request yields exactly one
// response on the out_ channel carrying given_id and status. Allocation
// starts just after the last id handed out, wraps to id 1 and never hands
// out id 0. The search reads one bitmap word per cycle from the memory.
// A free request reads only the word of its id; an allocation examines
// word after word until it finds a free bit, and when the map is full it
// reports STS_FULL after looking at the starting word a second time.
// Requests are handled one at a time: in_ready is high only while
// the block is idle, so a new request is taken only after the last one
// has loaded its response. The response sits in an output register;
// if the receiver stalls, a finished request holds in the search stage
// until the register drains, and nothing is written before then.
// Reset empties the bitmap at once through per-word valid bits and clears
// the last given id, so the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
module bitmap_id_allocator
  import bia_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bia_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output bia_out_t out_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic              cmd_r, cmd_nxt;
  waddr_t            word_r, word_nxt;
  logic [BIT_W-1:0]  pos_r, pos_nxt;
  logic              bad_r, bad_nxt;
  logic [CNT_W-1:0]  scan_cnt_r, scan_cnt_nxt;
  logic [ID_W-1:0]   last_given_r, last_given_nxt;
  logic              out_valid_r, out_valid_nxt;
  bia_out_t          out_data_r, out_data_nxt;

  bia_mem_req_t      mem_req;
  word_t             rd_word;

  logic              in_acc;
  logic              out_free;
  logic [ID_W:0]     lg_plus;
  logic [ID_W:0]     start;
  logic              id_bad;
  word_t             free_w;
  word_t             cand_w;
  logic              found;
  logic              fail;
  logic [BIT_W-1:0]  hit_bit;
  waddr_t            next_word;
  logic              bit_used;

  bia_bitmap_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .mem_req (mem_req),
    .rd_word (rd_word)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // The search starts just past the last id, wrapping to id 1.
  assign lg_plus = {1'b0, last_given_r} + (ID_W + 1)'(1);
  assign start   = (lg_plus < (ID_W + 1)'(ID_LIMIT)) ? lg_plus : (ID_W + 1)'(1);

  assign id_bad = (in_data.free_id == '0) ||
                  ({1'b0, in_data.free_id} >= (ID_W + 1)'(ID_LIMIT));

  // Free bits of the word under examination. Id 0 is never free, and on
  // the first look at the starting word the bits below the start are out.
  always_comb begin
    free_w = ~rd_word;
    if (word_r == '0) begin
      free_w[0] = 1'b0;
    end
    cand_w = free_w;
    if (scan_cnt_r == '0) begin
      for (int b = 0; b < WORD_BITS; b++) begin
        if (BIT_W'(b) < pos_r) begin
          cand_w[b] = 1'b0;
        end
      end
    end
  end

  assign found     = |cand_w;
  assign fail      = !found && (scan_cnt_r == CNT_W'(WORDS));
  assign hit_bit   = lowest_set(cand_w);
  assign next_word = (word_r == waddr_t'(WORDS - 1)) ? '0 : word_r + waddr_t'(1);
  assign bit_used  = rd_word[pos_r];

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    word_nxt       = word_r;
    pos_nxt        = pos_r;
    bad_nxt        = bad_r;
    scan_cnt_nxt   = scan_cnt_r;
    last_given_nxt = last_given_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    mem_req        = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt      = in_data.command;
          scan_cnt_nxt = '0;
          bad_nxt      = id_bad;
          if (in_data.command == CMD_ALLOC) begin
            word_nxt = start[BIT_W +: ADDR_W];
            pos_nxt  = start[BIT_W-1:0];
          end else begin
            word_nxt = in_data.free_id[BIT_W +: ADDR_W];
            pos_nxt  = in_data.free_id[BIT_W-1:0];
          end
          mem_req.re    = 1'b1;
          mem_req.raddr = word_nxt;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cmd_r == CMD_ALLOC) begin
          if (found || fail) begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              state_nxt     = S_IDLE;
              if (found) begin
                mem_req.we             = 1'b1;
                mem_req.waddr          = word_r;
                mem_req.wdata          = rd_word;
                mem_req.wdata[hit_bit] = 1'b1;
                last_given_nxt         = ID_W'({word_r, hit_bit});
                out_data_nxt.given_id  = ID_W'({word_r, hit_bit});
                out_data_nxt.status    = STS_OK;
              end else begin
                out_data_nxt.given_id  = '0;
                out_data_nxt.status    = STS_FULL;
              end
            end
          end else begin
            // Nothing free here: move on to the following word.
            mem_req.re    = 1'b1;
            mem_req.raddr = next_word;
            word_nxt      = next_word;
            scan_cnt_nxt  = scan_cnt_r + CNT_W'(1);
          end
        end else begin
          if (out_free) begin
            out_valid_nxt         = 1'b1;
            state_nxt             = S_IDLE;
            out_data_nxt.given_id = '0;
            if (bad_r) begin
              out_data_nxt.status = STS_BAD_ID;
            end else if (!bit_used) begin
              out_data_nxt.status = STS_NOT_USED;
            end else begin
              mem_req.we           = 1'b1;
              mem_req.waddr        = word_r;
              mem_req.wdata        = rd_word;
              mem_req.wdata[pos_r] = 1'b0;
              out_data_nxt.status  = STS_OK;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      last_given_r <= '0;
      out_valid_r  <= 1'b0;
      scan_cnt_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      last_given_r <= last_given_nxt;
      out_valid_r  <= out_valid_nxt;
      scan_cnt_r   <= scan_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    word_r     <= word_nxt;
    pos_r      <= pos_nxt;
    bad_r      <= bad_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A new response can only be loaded from the search stage.
  a_rsp_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_SCAN))
    else $error("response raised outside the search stage");

  // The bitmap is only written when a request completes.
  a_write_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == S_SCAN) && out_free)
    else $error("bitmap written while no request completes");

  // A nonzero id is only ever returned with a good status; errors carry id 0.
  a_id_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_data_r.status != STS_OK) |-> (out_data_r.given_id == '0))
    else $error("id returned with an error status");

  // The wrap-around search never walks past the starting word again.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scan_cnt_r <= CNT_W'(WORDS))
    else $error("search ran past the full word count");

endmodule

[hw/rtl/bia_bitmap_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap word memory
// One write and one registered read port, with per-word valid bits so that
// a word never written since reset reads as all zeros.
// ----------------------------------------------------------------------------
module bia_bitmap_ram
  import bia_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  bia_mem_req_t mem_req,
  output word_t        rd_word
);

  word_t              mem [WORDS];
  logic [WORDS-1:0]   vld_r;
  word_t              rd_data_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    if (mem_req.re) begin
      rd_data_r <= mem[mem_req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_req.we) begin
        vld_r[mem_req.waddr] <= 1'b1;
      end
      if (mem_req.re) begin
        rd_vld_r <= vld_r[mem_req.raddr];
      end
    end
  end

  assign rd_word = rd_vld_r ? rd_data_r : '0;

endmodule
